### rtl/cia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants of the checked integer ALU
// Opcodes, item classes, error codes and the word passed from front to back.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrWidth   = $clog2(QueueDepth);
  localparam int unsigned CntWidth   = $clog2(QueueDepth + 1);

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [3:0] {
    OP_UPLUS  = 4'd0,
    OP_UMINUS = 4'd1,
    OP_BITNOT = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_MUL    = 4'd5,
    OP_DIV    = 4'd6,
    OP_MOD    = 4'd7,
    OP_SHL    = 4'd8,
    OP_SHR    = 4'd9,
    OP_AND    = 4'd10,
    OP_OR     = 4'd11,
    OP_XOR    = 4'd12,
    OP_POW    = 4'd13,
    OP_CONCAT = 4'd14,
    OP_UNSUP  = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    CLS_SIMPLE,
    CLS_DIV,
    CLS_POW,
    CLS_CAT,
    CLS_FAULT,
    CLS_UNSUP
  } class_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_ARITH = 2'd1,
    ERR_UNSUP = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POW,
    ST_CAT,
    ST_WRITE
  } state_e;

  typedef struct packed {
    op_e    op;
    class_e cls;
    word_t  a;
    word_t  b;
    logic   clr;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } front_t;

endpackage

### rtl/cia_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_front: input acceptance and classification
// Classifies each word by opcode and operand faults and queues it.
// ----------------------------------------------------------------------------
module cia_front import cia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        clear_error_i,
  output front_t      front_o,
  input  logic        take_i
);

  entry_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  entry_t                new_entry;
  logic                  do_push, do_pop;
  logic signed [WordWidth-1:0] sa, sb;
  logic                  div_fault;

  assign sa = $signed(operand_a_i[WordWidth-1:0]);
  assign sb = $signed(operand_b_i[WordWidth-1:0]);
  assign div_fault = (sb == '0) ||
                     ((sa == {1'b1, {(WordWidth-1){1'b0}}}) && (sb == '1));

  always_comb begin
    new_entry.op  = op_e'(cmd_i);
    new_entry.a   = sa;
    new_entry.b   = sb;
    new_entry.clr = clear_error_i;
    new_entry.cls = CLS_SIMPLE;
    case (new_entry.op)
      OP_DIV, OP_MOD: new_entry.cls = div_fault ? CLS_FAULT : CLS_DIV;
      OP_SHL, OP_SHR: begin
        if (sb < 0 || sb >= $signed(WordWidth)) begin
          new_entry.cls = CLS_FAULT;
        end
      end
      OP_POW:    new_entry.cls = sb[WordWidth-1] ? CLS_FAULT : CLS_POW;
      OP_CONCAT: new_entry.cls = sb[WordWidth-1] ? CLS_SIMPLE : CLS_CAT;
      OP_UNSUP:  new_entry.cls = CLS_UNSUP;
      default:   new_entry.cls = CLS_SIMPLE;
    endcase
  end

  assign full    = (cnt_q == CntWidth'(QueueDepth));
  assign do_push = push && !full;
  assign do_pop  = take_i && (cnt_q != '0);

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntWidth'(do_push) - CntWidth'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= new_entry;
    end
  end

  assign front_o.valid = (cnt_q != '0);
  assign front_o.entry = mem_q[rd_q];

endmodule

### rtl/cia_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_back: execution unit
// Runs simple operations at once and division, power and concatenation
// iteratively, keeps the sticky error and holds the result word.
// ----------------------------------------------------------------------------
module cia_back import cia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  front_t      front_i,
  output logic        take_o,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] result_o,
  output logic [1:0]  error_code_o
);

  localparam int unsigned DivCntW = $clog2(WordWidth + 1);
  localparam int unsigned CatW    = WordWidth + 6;
  localparam logic [CatW-1:0] CatOvf = CatW'(1) << (WordWidth + 1);
  localparam logic [CatW-1:0] MaxPos = (CatW'(1) << (WordWidth - 1)) - 1'b1;
  localparam logic [CatW-1:0] MaxNeg = CatW'(1) << (WordWidth - 1);

  state_e state_q, state_d;
  entry_t ent;
  err_e   held_q, held_d, eff_err, imm_err;
  logic   out_valid_q, out_valid_d, out_free;
  word_t  res_q, res_d, fin_q, fin_d, imm_res;
  err_e   err_q, err_d;
  logic   immediate;

  op_e    op_q, op_d;
  word_t  a_q, a_d, b_q, b_d;
  word_t  quo_q, quo_d, dvs_q, dvs_d;
  logic [WordWidth:0] rem_q, rem_d, trial;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  word_t  acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic   phase_q, phase_d;
  logic [CatW-1:0] p_q, p_d, t_q, t_d, tot, t_init;
  logic   ovf_q, ovf_d, cat_fault;
  word_t  mag, mul_x, mul_y, prod, div_res;

  assign ent      = front_i.entry;
  assign eff_err  = ent.clr ? ERR_NONE : held_q;
  assign out_free = !out_valid_q || pop;
  assign immediate = (eff_err != ERR_NONE) || (ent.cls == CLS_SIMPLE) ||
                     (ent.cls == CLS_FAULT) || (ent.cls == CLS_UNSUP);

  always_comb begin
    mul_x = ent.a;
    mul_y = ent.b;
    if (state_q == ST_POW) begin
      mul_x = phase_q ? base_q : acc_q;
      mul_y = base_q;
    end
  end
  assign prod = mul_x * mul_y;

  always_comb begin
    imm_err = ERR_NONE;
    imm_res = '0;
    if (eff_err != ERR_NONE) begin
      imm_err = eff_err;
    end else if (ent.cls == CLS_FAULT) begin
      imm_err = ERR_ARITH;
    end else if (ent.cls == CLS_UNSUP) begin
      imm_err = ERR_UNSUP;
    end else begin
      case (ent.op)
        OP_UPLUS:  imm_res = ent.a;
        OP_UMINUS: imm_res = '0 - ent.a;
        OP_BITNOT: imm_res = ~ent.a;
        OP_ADD:    imm_res = ent.a + ent.b;
        OP_SUB:    imm_res = ent.a - ent.b;
        OP_MUL:    imm_res = prod;
        OP_SHL:    imm_res = ent.a << ent.b[$clog2(WordWidth)-1:0];
        OP_SHR:    imm_res = $signed(ent.a) >>> ent.b[$clog2(WordWidth)-1:0];
        OP_AND:    imm_res = ent.a & ent.b;
        OP_OR:     imm_res = ent.a | ent.b;
        OP_XOR:    imm_res = ent.a ^ ent.b;
        OP_CONCAT: imm_res = ent.a;
        default:   imm_res = '0;
      endcase
    end
  end

  assign mag    = ent.a[WordWidth-1] ? '0 - ent.a : ent.a;
  assign t_init = (CatW'(mag) << 3) + (CatW'(mag) << 1);
  assign trial  = {rem_q[WordWidth-1:0], quo_q[WordWidth-1]};
  assign tot    = t_q + CatW'(b_q);
  assign cat_fault = ovf_q || (a_q[WordWidth-1] ? (tot > MaxNeg) : (tot > MaxPos));

  always_comb begin
    div_res = quo_q;
    if (op_q == OP_DIV) begin
      div_res = (a_q[WordWidth-1] ^ b_q[WordWidth-1]) ? '0 - quo_q : quo_q;
    end else begin
      div_res = a_q[WordWidth-1] ? '0 - rem_q[WordWidth-1:0] : rem_q[WordWidth-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (front_i.valid && !immediate) begin
          case (ent.cls)
            CLS_DIV: state_d = ST_DIV;
            CLS_POW: state_d = ST_POW;
            default: state_d = ST_CAT;
          endcase
        end
      end
      ST_DIV: if (dcnt_q == DivCntW'(WordWidth)) state_d = ST_WRITE;
      ST_POW: if (!phase_q && exp_q == '0) state_d = ST_WRITE;
      ST_CAT: begin
        if (CatW'(b_q) < p_q) begin
          if (!cat_fault) begin
            state_d = ST_WRITE;
          end else if (out_free) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_WRITE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    take_o      = 1'b0;
    out_valid_d = out_valid_q && !pop;
    res_d = res_q;  err_d = err_q;  held_d = held_q;  fin_d = fin_q;
    op_d = op_q;  a_d = a_q;  b_d = b_q;
    quo_d = quo_q;  dvs_d = dvs_q;  rem_d = rem_q;  dcnt_d = dcnt_q;
    acc_d = acc_q;  base_d = base_q;  exp_d = exp_q;  phase_d = phase_q;
    p_d = p_q;  t_d = t_q;  ovf_d = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (front_i.valid) begin
          op_d = ent.op;  a_d = ent.a;  b_d = ent.b;
          if (immediate) begin
            if (out_free) begin
              take_o      = 1'b1;
              out_valid_d = 1'b1;
              res_d       = imm_res;
              err_d       = imm_err;
              held_d      = imm_err;
            end
          end else begin
            take_o  = 1'b1;
            quo_d   = mag;
            dvs_d   = ent.b[WordWidth-1] ? '0 - ent.b : ent.b;
            rem_d   = '0;
            dcnt_d  = '0;
            acc_d   = word_t'(1);
            base_d  = ent.a;
            exp_d   = ent.b;
            phase_d = 1'b0;
            p_d     = CatW'(10);
            t_d     = t_init;
            ovf_d   = (t_init >= CatOvf);
          end
        end
      end
      ST_DIV: begin
        if (dcnt_q == DivCntW'(WordWidth)) begin
          fin_d = div_res;
        end else begin
          if (trial >= {1'b0, dvs_q}) begin
            rem_d = trial - {1'b0, dvs_q};
            quo_d = {quo_q[WordWidth-2:0], 1'b1};
          end else begin
            rem_d = trial;
            quo_d = {quo_q[WordWidth-2:0], 1'b0};
          end
          dcnt_d = dcnt_q + 1'b1;
        end
      end
      ST_POW: begin
        if (!phase_q) begin
          if (exp_q == '0) begin
            fin_d = acc_q;
          end else begin
            if (exp_q[0]) acc_d = prod;
            phase_d = 1'b1;
          end
        end else begin
          base_d  = prod;
          exp_d   = exp_q >> 1;
          phase_d = 1'b0;
        end
      end
      ST_CAT: begin
        if (CatW'(b_q) >= p_q) begin
          p_d   = (p_q << 3) + (p_q << 1);
          t_d   = (t_q << 3) + (t_q << 1);
          ovf_d = ovf_q || (((t_q << 3) + (t_q << 1)) >= CatOvf);
        end else if (cat_fault) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            res_d       = '0;
            err_d       = ERR_ARITH;
            held_d      = ERR_ARITH;
          end
        end else begin
          fin_d = a_q[WordWidth-1] ? '0 - tot[WordWidth-1:0] : tot[WordWidth-1:0];
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = fin_q;
          err_d       = ERR_NONE;
          held_d      = ERR_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;  err_q <= err_d;  fin_q <= fin_d;
    op_q <= op_d;  a_q <= a_d;  b_q <= b_d;
    quo_q <= quo_d;  dvs_q <= dvs_d;  rem_q <= rem_d;  dcnt_q <= dcnt_d;
    acc_q <= acc_d;  base_q <= base_d;  exp_q <= exp_d;  phase_q <= phase_d;
    p_q <= p_d;  t_q <= t_d;  ovf_q <= ovf_d;
  end

  assign empty        = !out_valid_q;
  assign result_o     = res_q;
  assign error_code_o = err_q;

endmodule

### rtl/checked_integer_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_integer_alu_top: signed integer ALU with sticky error code
// Queue-style input and result ports around a decoupled front and back.
// ----------------------------------------------------------------------------
// Simple operations, shifts and multiply are computed from the queued word
// and registered in the result word. Division and modulo run a restoring
// divider at one bit a cycle. Power shares one multiplier between squaring
// and accumulating, one step of each per exponent bit. Concatenation scales
// the left magnitude by ten per decimal digit of the right operand. A
// two-word queue lets new words be pushed while the back end works, and the
// result word is held until it is popped.
module checked_integer_alu_top import cia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        clear_error_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] result_o,
  output logic [1:0]  error_code_o
);

  front_t front;
  logic   take;

  cia_front u_front (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .operand_a_i, .operand_b_i,
    .clear_error_i, .front_o(front), .take_i(take)
  );

  cia_back u_back (
    .clk_i, .rst_ni, .front_i(front), .take_o(take), .empty, .pop,
    .result_o, .error_code_o
  );

endmodule

### rtl/cia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_checker: port-level checks of the checked integer ALU
// Watches the result side and is bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker import cia_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] result_o,
  input logic [1:0]  error_code_o
);

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> error_code_o != 2'd3) else $error("invalid error code");

  a_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_code_o != ERR_NONE) |-> result_o == '0)
    else $error("nonzero result with error held");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o) && $stable(error_code_o)))
    else $error("stalled result word changed");

endmodule

bind checked_integer_alu_top cia_checker u_cia_checker (
  .clk_i, .rst_ni, .empty, .pop, .result_o, .error_code_o
);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the checked integer ALU
// Directed corner cases, then random words with random gaps on both sides.
// A scoreboard predicts each result word, including the sticky error code,
// and compares it with the popped word.
// ----------------------------------------------------------------------------
module tb;
  import cia_pkg::*;

  class alu_scoreboard;
    err_e    held;
    word_t   exp_result[$];
    err_e    exp_error[$];
    int      mismatches;

    function new();
      held = ERR_NONE;
      mismatches = 0;
    endfunction

    function automatic longint concat_value(longint a, longint b, output bit fault);
      longint unsigned pw, mag, tot;
      pw = 10;
      fault = 0;
      if (b < 0) return a;
      while (longint'(pw) <= b) pw = pw * 10;
      mag = (a < 0) ? longint'(-a) : longint'(a);
      if (mag > (64'd1 << 40) / pw) begin
        fault = 1;
        return 0;
      end
      tot = mag * pw + longint'(b);
      if (a < 0) begin
        if (tot > 64'd2147483648) begin
          fault = 1;
          return 0;
        end
        return -longint'(tot);
      end
      if (tot > 64'd2147483647) begin
        fault = 1;
        return 0;
      end
      return longint'(tot);
    endfunction

    function void note_word(op_e op, word_t a, word_t b, bit clr);
      logic signed [31:0] sa, sb;
      word_t r, acc, base, e;
      bit fault;
      longint cv;
      sa = a;
      sb = b;
      r = '0;
      fault = 0;
      if (clr) held = ERR_NONE;
      if (held == ERR_NONE) begin
        case (op)
          OP_UPLUS:  r = a;
          OP_UMINUS: r = -a;
          OP_BITNOT: r = ~a;
          OP_ADD:    r = a + b;
          OP_SUB:    r = a - b;
          OP_MUL:    r = a * b;
          OP_DIV, OP_MOD: begin
            if (sb == 0 || (sa == 32'sh80000000 && sb == -1)) fault = 1;
            else r = (op == OP_DIV) ? sa / sb : sa % sb;
          end
          OP_SHL, OP_SHR: begin
            if (sb < 0 || sb > 31) fault = 1;
            else if (op == OP_SHL) r = a << sb[4:0];
            else r = sa >>> sb[4:0];
          end
          OP_AND:    r = a & b;
          OP_OR:     r = a | b;
          OP_XOR:    r = a ^ b;
          OP_POW: begin
            if (sb < 0) fault = 1;
            else begin
              acc = 1;
              base = a;
              e = b;
              while (e != 0) begin
                if (e[0]) acc = acc * base;
                base = base * base;
                e = e >> 1;
              end
              r = acc;
            end
          end
          OP_CONCAT: begin
            cv = concat_value(longint'(sa), longint'(sb), fault);
            r = cv[31:0];
          end
          default: held = ERR_UNSUP;
        endcase
        if (fault && held == ERR_NONE) held = ERR_ARITH;
        if (fault || held != ERR_NONE) r = '0;
      end
      exp_result.push_back(r);
      exp_error.push_back(held);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task check_word(word_t r, logic [1:0] ec);
      if (exp_result.size() == 0) begin
        report($sformatf("unexpected result word %h err %0d", r, ec));
        return;
      end
      if (r !== exp_result[0]) begin
        report($sformatf("result %h, expected %h", r, exp_result[0]));
      end
      if (ec !== exp_error[0]) begin
        report($sformatf("error code %0d, expected %0d", ec, exp_error[0]));
      end
      void'(exp_result.pop_front());
      void'(exp_error.pop_front());
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [3:0]  cmd_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        clear_error_i = 0;
  logic        empty;
  logic        pop = 0;
  logic [31:0] result_o;
  logic [1:0]  error_code_o;

  alu_scoreboard sb = new();
  bit sender_done = 0;
  bit hold_off = 0;

  checked_integer_alu_top dut (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .operand_a_i, .operand_b_i,
    .clear_error_i, .empty, .pop, .result_o, .error_code_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_word(op_e op, word_t a, word_t b, bit clr, bit gaps);
    int unsigned wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 9) : 0;
    if (wait_cycles != 0) begin
      push <= 0;
      repeat (wait_cycles) @(negedge clk_i);
    end
    push <= 1;
    cmd_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    clear_error_i <= clr;
    do @(posedge clk_i); while (full);
    sb.note_word(op, a, b, clr);
    @(negedge clk_i);
  endtask

  function automatic word_t pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 40);
      1: return -$urandom_range(0, 40);
      2: return {1'($urandom_range(0, 1)), 31'd0} - $urandom_range(0, 1);
      3: return $urandom_range(0, 99999);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(bit gaps);
    op_e op;
    word_t a, b;
    op = op_e'($urandom_range(0, 15));
    if ($urandom_range(0, 15) == 0) op = OP_UNSUP;
    else if (op == OP_UNSUP) op = OP_ADD;
    a = pick_operand();
    b = pick_operand();
    if (op inside {OP_SHL, OP_SHR} && $urandom_range(0, 3) != 0) b = $urandom_range(0, 31);
    if (op == OP_POW && $urandom_range(0, 3) != 0) b = $urandom_range(0, 40);
    if (op == OP_CONCAT && $urandom_range(0, 1)) begin
      a = $urandom_range(0, 9999) * ($urandom_range(0, 1) ? 1 : -1);
      b = $urandom_range(0, 99999);
    end
    send_word(op, a, b, $urandom_range(0, 2) == 0, gaps);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    for (int i = 0; i < 15; i++) send_word(op_e'(i), 32'h7fffffff, 32'h3, 1, 0);
    send_word(OP_DIV, 32'h80000000, 32'hffffffff, 1, 0);
    send_word(OP_ADD, 32'h1, 32'h1, 0, 0);
    send_word(OP_MOD, 32'h5, 32'h0, 1, 0);
    send_word(OP_SHL, 32'h1, 32'd32, 1, 0);
    send_word(OP_SHR, 32'h80000000, 32'd31, 1, 0);
    send_word(OP_POW, 32'h0, 32'h0, 1, 0);
    send_word(OP_POW, 32'h3, 32'hffffffff, 1, 0);
    send_word(OP_CONCAT, 32'hfffffff4, 32'h22, 1, 0);
    send_word(OP_CONCAT, 32'd214748364, 32'd8, 1, 0);
    send_word(OP_CONCAT, 32'h5, 32'hffffffff, 1, 0);
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_random(0);
    push <= 0;
    hold_off = 0;
    wait (sb.exp_result.size() == 0);
    for (int i = 0; i < 1500; i++) send_random($urandom_range(0, 3) != 0);
    push <= 0;
    sender_done = 1;
  end

  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        repeat (200) @(negedge clk_i);
        hold_off = 0;
      end
      stall = $urandom_range(0, 1) ? $urandom_range(0, 9) : 0;
      repeat (stall) @(negedge clk_i);
      pop <= 1;
      do @(posedge clk_i); while (empty);
      sb.check_word(result_o, error_code_o);
      @(negedge clk_i);
      pop <= 0;
    end
  end

  initial begin
    wait (sender_done && sb.exp_result.size() == 0);
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.exp_result.size() == 0) $display("checked_integer_alu_top test passed");
    else $display("checked_integer_alu_top test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("checked_integer_alu_top test failed");
    $finish;
  end
endmodule

### sim.f
rtl/cia_pkg.sv
rtl/cia_front.sv
rtl/cia_back.sv
rtl/checked_integer_alu_top.sv
rtl/cia_checker.sv
test/tb.sv
